// ===== rtl/two_wire_sensor_bus_master_core_macros.svh =====
// ----------------------------------------------------------------------------
// two-wire sensor bus master assertion macros
// shared concurrent assertion helpers for the bus master rtl
// ----------------------------------------------------------------------------
`ifndef TWO_WIRE_SENSOR_BUS_MASTER_CORE_MACROS_SVH
`define TWO_WIRE_SENSOR_BUS_MASTER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TWSBM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twsbm assertion failed");

// next-cycle implication, disabled during reset
`define TWSBM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twsbm assertion failed");

`endif

// ===== rtl/twsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// twsbm_pkg
// types, codes and crc helpers for the two-wire sensor bus master
// ----------------------------------------------------------------------------
package twsbm_pkg;

  // configuration defaults
  localparam logic [7:0]  PHASE_TICKS_RST = 8'd20;
  localparam logic [17:0] WAIT_LIMIT_RST  = 18'd250000;
  localparam logic        CRC_ENABLE_RST  = 1'b1;
  localparam int          RECOVERY_CLOCKS_DEF = 9;

  // configuration register indexes
  localparam logic [1:0] CFG_PHASE_TICKS = 2'd0;
  localparam logic [1:0] CFG_WAIT_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_CRC_ENABLE  = 2'd2;

  // operation codes
  localparam logic [1:0] OP_TEMP    = 2'd0;
  localparam logic [1:0] OP_HUMI    = 2'd1;
  localparam logic [1:0] OP_SREG    = 2'd2;
  localparam logic [1:0] OP_ILLEGAL = 2'd3;

  // sensor command bytes
  localparam logic [7:0] CMD_TEMP = 8'h03;
  localparam logic [7:0] CMD_HUMI = 8'h05;
  localparam logic [7:0] CMD_SREG = 8'h07;

  // status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_NACK    = 3'd1;
  localparam logic [2:0] STAT_CRC     = 3'd2;
  localparam logic [2:0] STAT_TIMEOUT = 3'd3;
  localparam logic [2:0] STAT_ILLEGAL = 3'd4;

  localparam logic [7:0] CRC_POLY = 8'h31;

  // start pattern per segment, bit i is segment i
  localparam logic [5:0] START_SCL = 6'b110110;
  localparam logic [5:0] START_LOW = 6'b011100;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_START      = 4'd1,
    ST_WRITE      = 4'd2,
    ST_WACK       = 4'd3,
    ST_POLL       = 4'd4,
    ST_READ       = 4'd5,
    ST_RACK       = 4'd6,
    ST_RECOVER    = 4'd7,
    ST_RSTART     = 4'd8,
    ST_REPORT     = 4'd9,
    ST_REPORT_ILL = 4'd10
  } seq_state_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] operation;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl;
    logic        sda_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] value;
  } out_item_t;

  // crc-8 update over one byte, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] a;
    a = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      a = a[7] ? ((a << 1) ^ CRC_POLY) : (a << 1);
    end
    return a;
  endfunction

  // bit order reversal of a byte
  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/two_wire_sensor_bus_master_core.sv =====
// result: each accepted tick's result is registered and presented in the cycle after it
// throughput: one tick per cycle; the sequencer state and result register
//   update together in a single pass, so ready only drops when a result is stalled
// reset: synchronous active-low rst_n returns the sequencer to idle, clears counters
//   and loads the configuration defaults; no clearing pass
// ----------------------------------------------------------------------------
// two_wire_sensor_bus_master_core
// tick-driven bus master for a two-wire humidity and temperature sensor:
// start pattern, command write, ack, ready poll, byte reads and crc-8 check
// ----------------------------------------------------------------------------
`include "two_wire_sensor_bus_master_core_macros.svh"

module two_wire_sensor_bus_master_core import twsbm_pkg::*; #(
  parameter int RECOVERY_CLOCKS = RECOVERY_CLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick input
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  localparam logic [17:0] RecoverEnd = 18'(2 * RECOVERY_CLOCKS);

  // configuration registers
  logic [7:0]  phase_ticks_r;
  logic [17:0] wait_limit_r;
  logic        crc_enable_r;

  // sequencer state
  seq_state_t  state_r, state_nxt;
  logic [7:0]  phase_count_r, phase_count_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [1:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [15:0] data_hold_r, data_hold_nxt;
  logic [7:0]  crc_acc_r, crc_acc_nxt;
  logic [17:0] wait_count_r, wait_count_nxt;
  logic [7:0]  command_latch_r, command_latch_nxt;

  // result register
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   res;

  logic        in_fire;
  logic [7:0]  ticks;
  logic        seg_end;
  logic [1:0]  last_byte;
  logic        rack_more;
  logic [17:0] wait_inc;
  logic [7:0]  cmd_sel;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      wait_limit_r  <= WAIT_LIMIT_RST;
      crc_enable_r  <= CRC_ENABLE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_data[7:0];
        CFG_WAIT_LIMIT:  wait_limit_r  <= cfg_data;
        CFG_CRC_ENABLE:  crc_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-tick bus outputs and next state
  always_comb begin
    state_nxt         = state_r;
    bit_count_nxt     = bit_count_r;
    byte_index_nxt    = byte_index_r;
    shift_byte_nxt    = shift_byte_r;
    data_hold_nxt     = data_hold_r;
    crc_acc_nxt       = crc_acc_r;
    wait_count_nxt    = wait_count_r;
    command_latch_nxt = command_latch_r;

    res          = '0;
    res.busy_res = 1'b1;

    ticks     = (phase_ticks_r == 8'd0) ? 8'd1 : phase_ticks_r;
    seg_end   = ({1'b0, phase_count_r} + 9'd1) >= {1'b0, ticks};
    last_byte = (command_latch_r == CMD_SREG) ? 2'd1 : 2'd2;
    rack_more = byte_index_r < last_byte;
    wait_inc  = wait_count_r + 18'd1;

    case (in_data.operation)
      OP_TEMP: cmd_sel = CMD_TEMP;
      OP_HUMI: cmd_sel = CMD_HUMI;
      default: cmd_sel = CMD_SREG;
    endcase

    // bus levels for this tick
    case (state_r)
      ST_START, ST_RSTART: begin
        if (bit_count_r < 4'd6) begin
          res.scl           = START_SCL[bit_count_r[2:0]];
          res.sda_drive_low = START_LOW[bit_count_r[2:0]];
        end
      end
      ST_WRITE: begin
        res.scl           = bit_count_r[0];
        res.sda_drive_low = !shift_byte_r[7];
      end
      ST_WACK, ST_READ: res.scl = bit_count_r[0];
      ST_RACK: begin
        res.scl           = bit_count_r[0];
        res.sda_drive_low = rack_more;
      end
      ST_POLL: ;
      ST_RECOVER: res.scl = !wait_count_r[0];
      ST_REPORT: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
        res.status   = {1'b0, byte_index_r};
        res.value    = (byte_index_r == STAT_OK[1:0]) ? data_hold_r : 16'd0;
      end
      ST_REPORT_ILL: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
        res.status   = STAT_ILLEGAL;
      end
      default: res.busy_res = 1'b0;
    endcase

    // segment tick counter
    phase_count_nxt = seg_end ? 8'd0 : phase_count_r + 8'd1;

    // sequencer transitions
    case (state_r)
      ST_START, ST_RSTART: begin
        if (seg_end) begin
          if (bit_count_r >= 4'd5) begin
            bit_count_nxt = 4'd0;
            state_nxt     = (state_r == ST_START) ? ST_WRITE : ST_REPORT;
          end else begin
            bit_count_nxt = bit_count_r + 4'd1;
          end
        end
      end
      ST_WRITE: begin
        if (seg_end) begin
          if (bit_count_r == 4'd15) begin
            bit_count_nxt = 4'd0;
            state_nxt     = ST_WACK;
          end else begin
            if (bit_count_r[0]) shift_byte_nxt = shift_byte_r << 1;
            bit_count_nxt = bit_count_r + 4'd1;
          end
        end
      end
      ST_WACK: begin
        if (seg_end) begin
          if (bit_count_r == 4'd0) begin
            bit_count_nxt = 4'd1;
          end else if (in_data.sda_in) begin
            state_nxt      = ST_RECOVER;
            byte_index_nxt = STAT_NACK[1:0];
            wait_count_nxt = 18'd0;
            bit_count_nxt  = 4'd0;
          end else begin
            bit_count_nxt  = 4'd0;
            shift_byte_nxt = 8'd0;
            wait_count_nxt = 18'd0;
            state_nxt      = (command_latch_r == CMD_SREG) ? ST_READ : ST_POLL;
          end
        end
      end
      ST_POLL: begin
        if (!in_data.sda_in) begin
          state_nxt       = ST_READ;
          bit_count_nxt   = 4'd0;
          phase_count_nxt = 8'd0;
          shift_byte_nxt  = 8'd0;
        end else if (wait_inc == 18'd0 || wait_inc >= wait_limit_r) begin
          state_nxt       = ST_RECOVER;
          byte_index_nxt  = STAT_TIMEOUT[1:0];
          wait_count_nxt  = 18'd0;
          phase_count_nxt = 8'd0;
          bit_count_nxt   = 4'd0;
        end else begin
          wait_count_nxt = wait_inc;
        end
      end
      ST_READ: begin
        if (seg_end) begin
          if (bit_count_r[0]) shift_byte_nxt = {shift_byte_r[6:0], in_data.sda_in};
          if (bit_count_r == 4'd15) begin
            bit_count_nxt = 4'd0;
            state_nxt     = ST_RACK;
          end else begin
            bit_count_nxt = bit_count_r + 4'd1;
          end
        end
      end
      ST_RACK: begin
        if (seg_end) begin
          if (bit_count_r == 4'd0) begin
            bit_count_nxt = 4'd1;
          end else if (rack_more) begin
            data_hold_nxt  = {data_hold_r[7:0], shift_byte_r};
            crc_acc_nxt    = crc8_update(crc_acc_r, shift_byte_r);
            byte_index_nxt = byte_index_r + 2'd1;
            bit_count_nxt  = 4'd0;
            shift_byte_nxt = 8'd0;
            state_nxt      = ST_READ;
          end else if (crc_enable_r && (crc_acc_r != bit_rev8(shift_byte_r))) begin
            state_nxt      = ST_RECOVER;
            byte_index_nxt = STAT_CRC[1:0];
            wait_count_nxt = 18'd0;
            bit_count_nxt  = 4'd0;
          end else begin
            byte_index_nxt = 2'd0;
            state_nxt      = ST_REPORT;
          end
        end
      end
      ST_RECOVER: begin
        if (seg_end) begin
          wait_count_nxt = wait_inc;
          if (wait_inc >= RecoverEnd) begin
            bit_count_nxt = 4'd0;
            state_nxt     = ST_RSTART;
          end
        end
      end
      ST_REPORT, ST_REPORT_ILL: state_nxt = ST_IDLE;
      default: begin
        // idle, and any unused code falls back here
        state_nxt = ST_IDLE;
        if (in_data.start_req) begin
          if (in_data.operation == OP_ILLEGAL) begin
            state_nxt = ST_REPORT_ILL;
          end else begin
            command_latch_nxt = cmd_sel;
            shift_byte_nxt    = cmd_sel;
            crc_acc_nxt       = crc8_update(8'd0, cmd_sel);
            data_hold_nxt     = 16'd0;
            byte_index_nxt    = 2'd0;
            bit_count_nxt     = 4'd0;
            phase_count_nxt   = 8'd0;
            wait_count_nxt    = 18'd0;
            state_nxt         = ST_START;
          end
        end
      end
    endcase
  end

  // sequencer registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      phase_count_r   <= '0;
      bit_count_r     <= '0;
      byte_index_r    <= '0;
      shift_byte_r    <= '0;
      data_hold_r     <= '0;
      crc_acc_r       <= '0;
      wait_count_r    <= '0;
      command_latch_r <= '0;
    end else if (in_fire) begin
      state_r         <= state_nxt;
      phase_count_r   <= phase_count_nxt;
      bit_count_r     <= bit_count_nxt;
      byte_index_r    <= byte_index_nxt;
      shift_byte_r    <= shift_byte_nxt;
      data_hold_r     <= data_hold_nxt;
      crc_acc_r       <= crc_acc_nxt;
      wait_count_r    <= wait_count_nxt;
      command_latch_r <= command_latch_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  // a report tick produces a done result
  `TWSBM_ASSERT_NXT(a_report_done, clk, rst_n,
    in_fire && (state_r == ST_REPORT || state_r == ST_REPORT_ILL),
    out_valid_r && out_data_r.done_res && !out_data_r.busy_res)

  // idle without a request stays idle and reports not busy
  `TWSBM_ASSERT_NXT(a_idle_quiet, clk, rst_n,
    in_fire && state_r == ST_IDLE && !in_data.start_req,
    state_r == ST_IDLE && !out_data_r.busy_res && !out_data_r.done_res)

  // recovery always carries a failure code to report
  `TWSBM_ASSERT_IMP(a_recover_code, clk, rst_n,
    state_r == ST_RECOVER,
    byte_index_r != STAT_OK[1:0])

  // start pattern segment index stays within the pattern
  `TWSBM_ASSERT_IMP(a_start_seg, clk, rst_n,
    state_r == ST_START || state_r == ST_RSTART,
    bit_count_r < 4'd6)

endmodule
